// File: design/addd_pkg.sv
`timescale 1ns / 1ps
package addd_pkg;

  // Window and ring geometry
  localparam int WINDOW     = 20;
  localparam int RING_DEPTH = 30;
  localparam int POS_W      = $clog2(WINDOW);
  localparam int RIDX_W     = $clog2(RING_DEPTH);

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int LEVEL_W  = 14;
  localparam int DETECT_W = 13;
  localparam int CNT_W    = 16;
  localparam int RSUM_W   = 21;
  localparam int RATE_W   = 24;
  localparam int FRAC_W   = 4;
  localparam int DELTA_W  = 10;
  localparam int SCALE_W  = 20;

  // Serial divider: one quotient bit per cycle
  localparam int DIV_STEPS = RATE_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  // Divide by three: multiply by ceil(2^16/3), keep the top bits
  localparam int                  RECIP_SH = 16;
  localparam logic [LEVEL_W:0]    RECIP3   = 15'd21846;

  // Register port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_CAL_OFFSET = 1'b0;
  localparam logic REG_RATE_SCALE = 1'b1;
  localparam logic [DELTA_W-1:0] CAL_OFFSET_RST = 10'd150;
  localparam logic [SCALE_W-1:0] RATE_SCALE_RST = 20'd17280;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
  localparam logic [CNT_W-1:0]    CNT_MAX    = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_LOW_BLEND,
    ST_THRESH,
    ST_THRESH_LOW,
    ST_DROP,
    ST_DIV_WAIT,
    ST_OUT
  } addd_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;        // sample item accepted
    logic calib;       // first window sets both levels
    logic count;       // bump windows-since-drop
    logic low_first;   // first low window only sets the low level
    logic low_blend;   // low = blend(window min, low)
    logic high_blend;  // high = blend(high, window max), re-arm
    logic thresh;      // threshold = blend(low, high)
    logic drop;        // new drop: ring, counters, start divide
    logic load_out;    // capture the result item
  } addd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic win_end;
    logic calibrated;
    logic below;
    logic first_pending;
    logic drop_seen;
    logic div_done;
  } addd_status_t;

endpackage

// File: design/adaptive_drip_drop_detector.sv
`timescale 1ns / 1ps
// Drip detector: takes one 12-bit light sample per item and emits one result item at
// the close of every window of 20 samples (the calibrating first window included),
// nothing for the other samples. A sample that does not close a window is taken with no
// stall, and samples can stream back to back. A window-closing sample keeps the input
// stalled through its evaluate, blend, threshold and output states; a drop adds the
// ring update and the 24-step serial divider that forms the drop rate. While a result
// item waits on out_stall the input is stalled as well. Registers: cal_offset at byte 0,
// rate_scale at byte 4; write them only while the block is idle.
module adaptive_drip_drop_detector (
  input  logic                                 clk,
  input  logic                                 rst,
  // Sample input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [addd_pkg::SAMPLE_W-1:0]        sample,
  // Result output
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 drop_event,
  output logic [addd_pkg::CNT_W-1:0]           drop_count,
  output logic [addd_pkg::RATE_W-1:0]          drop_rate,
  output logic signed [addd_pkg::DETECT_W-1:0] detect_level,
  output logic                                 led_on,
  output logic                                 in_drop,
  // Register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [addd_pkg::ADDR_W-1:0]          paddr,
  input  logic [addd_pkg::DATA_W-1:0]          pwdata,
  output logic [addd_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);
  import addd_pkg::*;

  logic [DELTA_W-1:0] cal_offset;
  logic [SCALE_W-1:0] rate_scale;
  logic               reg_sel;
  addd_cmd_t          cmd;
  addd_status_t       status;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_offset <= CAL_OFFSET_RST;
      rate_scale <= RATE_SCALE_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_CAL_OFFSET: cal_offset <= pwdata[DELTA_W-1:0];
        REG_RATE_SCALE: rate_scale <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_sel)
      REG_CAL_OFFSET: prdata = DATA_W'(cal_offset);
      REG_RATE_SCALE: prdata = DATA_W'(rate_scale);
      default:        prdata = '0;
    endcase
  end

  addd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  addd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample       (sample),
    .cal_offset   (cal_offset),
    .rate_scale   (rate_scale),
    .drop_event   (drop_event),
    .drop_count   (drop_count),
    .drop_rate    (drop_rate),
    .detect_level (detect_level),
    .led_on       (led_on),
    .in_drop      (in_drop)
  );

endmodule

// File: design/addd_div.sv
`timescale 1ns / 1ps
module addd_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [addd_pkg::RATE_W-1:0]  dividend,
  input  logic [addd_pkg::RSUM_W-1:0]  divisor,
  output logic                         done,
  output logic [addd_pkg::RATE_W-1:0]  quotient
);
  import addd_pkg::*;

  logic                busy;
  logic [DCNT_W-1:0]   count;
  logic [RSUM_W-1:0]   rem;
  logic [RATE_W-1:0]   quot;
  logic [RSUM_W-1:0]   dvs;
  logic                dvs_zero;
  logic [RSUM_W:0]     trial;
  logic                fits;

  // One restoring step
  assign trial = {rem, quot[RATE_W-1]} - {1'b0, dvs};
  assign fits  = ~trial[RSUM_W];

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= DCNT_W'(DIV_STEPS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quot     <= dividend;
      dvs      <= divisor;
      dvs_zero <= (divisor == '0);
    end else if (busy) begin
      rem  <= fits ? trial[RSUM_W-1:0] : {rem[RSUM_W-2:0], quot[RATE_W-1]};
      quot <= {quot[RATE_W-2:0], fits};
    end
  end

  // A zero sum gives a zero rate
  assign quotient = dvs_zero ? '0 : quot;

endmodule

// File: design/addd_ctrl.sv
`timescale 1ns / 1ps
module addd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  addd_pkg::addd_status_t status,
  output addd_pkg::addd_cmd_t    cmd
);
  import addd_pkg::*;

  addd_state_t state;
  addd_state_t state_next;
  logic        out_blocked;
  logic        take;

  assign out_blocked = out_valid & out_stall;
  assign in_stall    = (state != ST_IDLE) | out_blocked;
  assign take        = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_OUT) begin
        out_valid <= 1'b1;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take && status.win_end) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (!status.calibrated)       state_next = ST_THRESH;
        else if (!status.below)       state_next = ST_OUT;
        else if (status.first_pending) state_next = ST_THRESH;
        else                          state_next = ST_LOW_BLEND;
      end
      ST_LOW_BLEND:  state_next = ST_THRESH_LOW;
      ST_THRESH:     state_next = ST_OUT;
      ST_THRESH_LOW: state_next = status.drop_seen ? ST_OUT : ST_DROP;
      ST_DROP:       state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (status.div_done) state_next = ST_OUT;
      end
      ST_OUT:        state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    cmd.take = take;
    unique case (state)
      ST_IDLE: ;
      ST_EVAL: begin
        if (!status.calibrated) begin
          cmd.calib = 1'b1;
        end else begin
          cmd.count = 1'b1;
          if (!status.below)            cmd.high_blend = 1'b1;
          else if (status.first_pending) cmd.low_first  = 1'b1;
        end
      end
      ST_LOW_BLEND:  cmd.low_blend = 1'b1;
      ST_THRESH:     cmd.thresh    = 1'b1;
      ST_THRESH_LOW: cmd.thresh    = 1'b1;
      ST_DROP:       cmd.drop      = 1'b1;
      ST_DIV_WAIT: ;
      ST_OUT:        cmd.load_out  = 1'b1;
      default: ;
    endcase
  end

endmodule

// File: design/addd_dp.sv
`timescale 1ns / 1ps
module addd_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  addd_pkg::addd_cmd_t                 cmd,
  output addd_pkg::addd_status_t              status,
  input  logic [addd_pkg::SAMPLE_W-1:0]       sample,
  input  logic [addd_pkg::DELTA_W-1:0]        cal_offset,
  input  logic [addd_pkg::SCALE_W-1:0]        rate_scale,
  output logic                                drop_event,
  output logic [addd_pkg::CNT_W-1:0]          drop_count,
  output logic [addd_pkg::RATE_W-1:0]         drop_rate,
  output logic signed [addd_pkg::DETECT_W-1:0] detect_level,
  output logic                                led_on,
  output logic                                in_drop
);
  import addd_pkg::*;

  // Window tracking
  logic [POS_W-1:0]    window_position;
  logic [SAMPLE_W-1:0] window_min;
  logic [SAMPLE_W-1:0] window_max;
  logic [SAMPLE_W-1:0] wmin;
  logic [SAMPLE_W-1:0] wmax;
  logic [SAMPLE_W-1:0] min_next;
  logic [SAMPLE_W-1:0] max_next;
  logic                win_end;

  // Detector state
  logic                       calibrated;
  logic                       first_pending;
  logic                       drop_seen;
  logic                       led_flag;
  logic                       event_flag;
  logic signed [LEVEL_W-1:0]  high_level;
  logic signed [LEVEL_W-1:0]  low_level;
  logic signed [LEVEL_W-1:0]  threshold;
  logic signed [LEVEL_W-1:0]  wmin_lvl;
  logic signed [LEVEL_W-1:0]  wmax_lvl;
  logic [CNT_W-1:0]           windows_since_drop;
  logic [CNT_W-1:0]           drops;
  logic [RATE_W-1:0]          rate_reg;

  // Interval ring
  logic [CNT_W-1:0]   interval_ring [RING_DEPTH];
  logic [RIDX_W-1:0]  ring_index;
  logic [RIDX_W-1:0]  ring_index_next;
  logic [RSUM_W-1:0]  ring_sum;
  logic [RSUM_W-1:0]  ring_sum_next;

  // Blend unit
  logic signed [LEVEL_W-1:0] blend_heavy;
  logic signed [LEVEL_W-1:0] blend_light;
  logic signed [LEVEL_W+1:0] blend_sum;
  logic [LEVEL_W:0]          blend_mag;
  logic [2*LEVEL_W+1:0]      blend_prod;
  logic [LEVEL_W-1:0]        blend_quo;
  logic signed [LEVEL_W-1:0] blend_q;

  // Divider
  logic              div_done;
  logic [RATE_W-1:0] div_quot;

  assign min_next = (sample < window_min) ? sample : window_min;
  assign max_next = (sample > window_max) ? sample : window_max;
  assign win_end  = (window_position == POS_W'(WINDOW - 1));
  assign wmin_lvl = $signed({{(LEVEL_W-SAMPLE_W){1'b0}}, wmin});
  assign wmax_lvl = $signed({{(LEVEL_W-SAMPLE_W){1'b0}}, wmax});

  assign status.win_end       = win_end;
  assign status.calibrated    = calibrated;
  assign status.below         = wmin_lvl < threshold;
  assign status.first_pending = first_pending;
  assign status.drop_seen     = drop_seen;
  assign status.div_done      = div_done;

  // Window min/max over accepted samples
  always_ff @(posedge clk) begin
    if (rst) begin
      window_position <= '0;
      window_min      <= SAMPLE_MAX;
      window_max      <= '0;
    end else if (cmd.take) begin
      if (win_end) begin
        window_position <= '0;
        window_min      <= SAMPLE_MAX;
        window_max      <= '0;
      end else begin
        window_position <= window_position + 1'b1;
        window_min      <= min_next;
        window_max      <= max_next;
      end
    end
  end

  // Closed window extremes
  always_ff @(posedge clk) begin
    if (cmd.take && win_end) begin
      wmin <= min_next;
      wmax <= max_next;
    end
  end

  // (2*heavy + light)/3 toward zero via reciprocal multiply on the magnitude
  always_comb begin
    blend_heavy = low_level;
    blend_light = high_level;
    if (cmd.low_blend) begin
      blend_heavy = wmin_lvl;
      blend_light = low_level;
    end else if (cmd.high_blend) begin
      blend_heavy = high_level;
      blend_light = wmax_lvl;
    end
  end

  assign blend_sum  = (LEVEL_W+2)'(blend_heavy) + (LEVEL_W+2)'(blend_heavy)
                    + (LEVEL_W+2)'(blend_light);
  assign blend_mag  = blend_sum[LEVEL_W+1] ? (LEVEL_W+1)'(-blend_sum)
                                           : blend_sum[LEVEL_W:0];
  assign blend_prod = blend_mag * RECIP3;
  assign blend_quo  = blend_prod[RECIP_SH +: LEVEL_W];
  assign blend_q    = blend_sum[LEVEL_W+1] ? -$signed(blend_quo) : $signed(blend_quo);

  // Ring bookkeeping for a new drop
  assign ring_index_next = (ring_index == RIDX_W'(RING_DEPTH - 1)) ? '0
                                                                   : ring_index + 1'b1;
  assign ring_sum_next   = ring_sum - RSUM_W'(interval_ring[ring_index_next])
                         + RSUM_W'(windows_since_drop);

  // Level adaptation, counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      calibrated         <= 1'b0;
      first_pending      <= 1'b1;
      drop_seen          <= 1'b0;
      led_flag           <= 1'b0;
      event_flag         <= 1'b0;
      high_level         <= '0;
      low_level          <= '0;
      threshold          <= '0;
      windows_since_drop <= '0;
      drops              <= '0;
      rate_reg           <= '0;
      ring_index         <= '0;
      ring_sum           <= '0;
      for (int i = 0; i < RING_DEPTH; i++) interval_ring[i] <= '0;
    end else begin
      if (cmd.take && win_end) event_flag <= 1'b0;
      if (cmd.calib) begin
        calibrated <= 1'b1;
        high_level <= wmax_lvl;
        low_level  <= wmin_lvl - $signed({{(LEVEL_W-DELTA_W){1'b0}}, cal_offset});
      end
      if (cmd.count && windows_since_drop != CNT_MAX) begin
        windows_since_drop <= windows_since_drop + 1'b1;
      end
      if (cmd.low_first) begin
        low_level     <= wmin_lvl;
        first_pending <= 1'b0;
      end
      if (cmd.low_blend) low_level <= blend_q;
      if (cmd.high_blend) begin
        high_level <= blend_q;
        drop_seen  <= 1'b0;
      end
      if (cmd.thresh) threshold <= blend_q;
      if (cmd.drop) begin
        ring_index                     <= ring_index_next;
        ring_sum                       <= ring_sum_next;
        interval_ring[ring_index_next] <= windows_since_drop;
        windows_since_drop             <= '0;
        if (drops != CNT_MAX) drops <= drops + 1'b1;
        drop_seen  <= 1'b1;
        led_flag   <= 1'b1;
        event_flag <= 1'b1;
      end
      if (div_done) rate_reg <= div_quot;
    end
  end

  // Rate = 16 * rate_scale / ring_sum
  addd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.drop),
    .dividend ({rate_scale, {FRAC_W{1'b0}}}),
    .divisor  (ring_sum_next),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Result item register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      drop_event   <= event_flag;
      drop_count   <= drops;
      drop_rate    <= rate_reg;
      detect_level <= threshold[DETECT_W-1:0];
      led_on       <= led_flag;
      in_drop      <= drop_seen;
    end
  end

endmodule

// File: design/addd_checker.sv
`timescale 1ns / 1ps
module addd_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 drop_event,
  input logic [addd_pkg::CNT_W-1:0]           drop_count,
  input logic [addd_pkg::RATE_W-1:0]          drop_rate,
  input logic                                 led_on,
  input logic                                 in_drop
);

  // A waiting result item holds its valid and its count
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(drop_count))
    else $error("result item dropped or changed while stalled");

  // A new drop lights the indicator and marks the drop in progress
  a_event_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && drop_event |-> led_on && in_drop && drop_count != '0)
    else $error("drop item without indicator, in-drop or count");

  // Before the first drop there is neither a count nor a rate
  a_no_drop_yet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !led_on |-> drop_count == '0 && drop_rate == '0 && !in_drop)
    else $error("count or rate reported before any drop");

  // No sample is taken while a result item is held back
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("sample accepted while result item stalled");

endmodule

bind adaptive_drip_drop_detector addd_checker u_addd_checker (.*);
